[rtl/arpis_pkg.sv]
// ----------------------------------------------------------------------------
// arpis_pkg
// shared types and constants of the arpeggiator index sequencer
// ----------------------------------------------------------------------------
package arpis_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_STEP   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    MODE_UP       = 3'd0,
    MODE_DOWN     = 3'd1,
    MODE_RANDOM   = 3'd2,
    MODE_OCT_UP   = 3'd3,
    MODE_OCT_DOWN = 3'd4,
    MODE_RST_UP   = 3'd5,
    MODE_RST_DOWN = 3'd6
  } arp_mode_e;

  typedef enum logic [1:0] {
    DIV_NOTE_POS = 2'd0,
    DIV_CC_POS   = 2'd1,
    DIV_LFSR     = 2'd2
  } div_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_APPLY,
    ST_RDIV_N,
    ST_RWAIT_N,
    ST_RDIV_C,
    ST_RWAIT_C,
    ST_STEP,
    ST_LOC,
    ST_ARITH,
    ST_OCT1,
    ST_OCT2,
    ST_DRAW,
    ST_DWAIT,
    ST_FIN
  } state_e;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  // controller to datapath
  typedef struct packed {
    logic     latch;
    logic     apply;
    logic     corr;
    logic     loc_clr;
    logic     loc_step;
    logic     arith;
    logic     div_start;
    div_sel_e div_sel;
    logic     div_wr;
    logic     lfsr_adv;
    logic     shift_set;
    logic     fin;
    logic     fin_zero;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e        op;
    logic       fwd;
    logic [2:0] mode;
    logic       rem_ok;
    logic       totals_zero;
    logic       note_nonzero;
    logic       loc_done;
    logic       div_done;
    logic       lfsr_bit;
    logic       note_found;
    logic       next_zero;
  } sts_t;

endpackage

[rtl/arpis_div.sv]
// ----------------------------------------------------------------------------
// arpis_div
// restoring remainder unit, one numerator bit per cycle
// ----------------------------------------------------------------------------
module arpis_div #(
  parameter int NW = 16,
  parameter int TW = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [TW-1:0] den_i,
  output logic          done_o,
  output logic [TW-1:0] rem_o
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_q, num_d;
  logic [TW-1:0] rem_q, rem_d, den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          run_q, run_d, done_q, done_d;
  logic [TW:0]   trial;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = {rem_q, num_q[NW-1]};
    if (start_i) begin
      num_d = num_i;
      den_d = den_i;
      rem_d = '0;
      cnt_d = CW'(NW);
      run_d = 1'b1;
    end else if (run_q) begin
      num_d = {num_q[NW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = TW'(trial - {1'b0, den_q});
      end else begin
        rem_d = trial[TW-1:0];
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[rtl/arpis_dp.sv]
// ----------------------------------------------------------------------------
// arpis_dp
// datapath: held list, count tables, totals, positions, walk and lfsr
// ----------------------------------------------------------------------------
module arpis_dp #(
  parameter int NUM_PADS    = 16,
  parameter int MAX_PER_PAD = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  arpis_pkg::cmd_t    cmd_i,
  output arpis_pkg::sts_t    sts_o,
  input  logic [1:0]         op_i,
  input  logic [3:0]         pad_i,
  input  logic [7:0]         pad_note_count_i,
  input  logic [7:0]         pad_cc_count_i,
  input  logic               forward_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_wdata_i,
  output logic               done_o,
  output logic               note_valid_o,
  output logic [3:0]         note_pad_o,
  output logic [7:0]         note_local_index_o,
  output logic signed [1:0]  octave_shift_o,
  output logic               cc_valid_o,
  output logic [3:0]         cc_pad_o,
  output logic [7:0]         cc_local_index_o
);

  localparam int TW = $clog2(NUM_PADS * MAX_PER_PAD + 1);
  localparam int IW = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
  localparam int LW = $clog2(NUM_PADS + 1);
  localparam int NW = (TW > 16) ? TW : 16;

  // input item
  arpis_pkg::op_e op_q;
  logic [3:0]     pad_q;
  logic [7:0]     nc_q, cc_q;
  logic           fwd_q;

  // held state
  logic [3:0]          list_q [NUM_PADS];
  logic [3:0]          list_d [NUM_PADS];
  logic [NUM_PADS-1:0] mask_q;
  logic [LW-1:0]       len_q;
  logic [7:0]          ntab_q [NUM_PADS];
  logic [7:0]          ctab_q [NUM_PADS];
  logic [TW-1:0]       ntot_q, ctot_q, npos_q, cpos_q;
  logic                lwf_q;
  logic [15:0]         lfsr_q, lfsr_nx;
  logic [2:0]          mode_q;

  // walk
  logic [LW-1:0] wi_q;
  logic [TW-1:0] nrun_q, crun_q, nsum, csum;
  logic          nfound_q, cfound_q;
  logic [3:0]    npad_q, cpad_q;
  logic [7:0]    nloc_q, cloc_q;
  logic signed [1:0] shift_q;
  arpis_pkg::div_sel_e div_sel_q;

  logic [6:0]    pad_ext, p_ext;
  logic [IW-1:0] pad_idx, p_idx;
  logic [3:0]    p;
  logic          in_range, add_ok, rem_ok;
  logic [7:0]    nc_sat, cc_sat;
  logic [NUM_PADS-1:0] mark;
  logic [TW-1:0] ncorr, ccorr, nnext, cnext;
  logic          down_mode;

  logic          div_done;
  logic [TW-1:0] div_rem;
  logic [NW-1:0] div_num;
  logic [TW-1:0] div_den;

  function automatic logic [TW-1:0] corr_pos(input logic [TW-1:0] pos,
                                             input logic [TW-1:0] total,
                                             input logic fwd, input logic lwf);
    logic [TW:0] k;
    logic [TW:0] s;
    k = lwf ? (TW+1)'(2) : (TW+1)'(1);
    if (fwd) begin
      s = {1'b0, pos} + (TW+1)'(1);
      if (lwf) begin
        return pos;
      end
      return (s == {1'b0, total}) ? '0 : s[TW-1:0];
    end
    if ({1'b0, pos} >= k) begin
      s = {1'b0, pos} - k;
      return s[TW-1:0];
    end
    s = {1'b0, pos} + {1'b0, total};
    if (s < k) begin
      return '0;
    end
    s = s - k;
    return s[TW-1:0];
  endfunction

  assign pad_ext  = 7'(pad_q);
  assign pad_idx  = pad_ext[IW-1:0];
  assign in_range = pad_ext < 7'(NUM_PADS);
  assign add_ok   = in_range && !mask_q[pad_idx] && (len_q < LW'(NUM_PADS));
  assign rem_ok   = in_range && mask_q[pad_idx];
  assign nc_sat   = (nc_q > 8'(MAX_PER_PAD)) ? 8'(MAX_PER_PAD) : nc_q;
  assign cc_sat   = (cc_q > 8'(MAX_PER_PAD)) ? 8'(MAX_PER_PAD) : cc_q;

  // galois lfsr advance
  assign lfsr_nx = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? arpis_pkg::LFSR_TAPS : 16'h0000);

  // compaction of the held list on remove
  always_comb begin
    logic run;
    run = 1'b0;
    for (int k = 0; k < NUM_PADS; k++) begin
      run = run | ((list_q[k] == pad_q) && (LW'(k) < len_q));
      mark[k] = run;
    end
    for (int k = 0; k < NUM_PADS; k++) begin
      list_d[k] = list_q[k];
      if (k + 1 < NUM_PADS && mark[k]) begin
        list_d[k] = list_q[(k + 1) % NUM_PADS];
      end
    end
  end

  // walk of the held list
  assign p     = list_q[wi_q[IW-1:0]];
  assign p_ext = 7'(p);
  assign p_idx = p_ext[IW-1:0];
  assign nsum  = nrun_q + TW'(ntab_q[p_idx]);
  assign csum  = crun_q + TW'(ctab_q[p_idx]);

  assign ncorr = corr_pos(npos_q, ntot_q, fwd_q, lwf_q);
  assign ccorr = corr_pos(cpos_q, ctot_q, fwd_q, lwf_q);

  assign down_mode = (mode_q == arpis_pkg::MODE_DOWN) ||
                     (mode_q == arpis_pkg::MODE_OCT_DOWN) ||
                     (mode_q == arpis_pkg::MODE_RST_DOWN);
  always_comb begin
    if (down_mode) begin
      nnext = (npos_q == '0) ? ntot_q - TW'(1) : npos_q - TW'(1);
    end else begin
      nnext = (npos_q + TW'(1) == ntot_q) ? '0 : npos_q + TW'(1);
    end
    cnext = (cpos_q + TW'(1) == ctot_q) ? '0 : cpos_q + TW'(1);
  end

  // shared remainder unit
  always_comb begin
    case (cmd_i.div_sel)
      arpis_pkg::DIV_CC_POS: begin
        div_num = NW'(cpos_q);
        div_den = ctot_q;
      end
      arpis_pkg::DIV_LFSR: begin
        div_num = NW'(lfsr_nx);
        div_den = ntot_q;
      end
      default: begin
        div_num = NW'(npos_q);
        div_den = ntot_q;
      end
    endcase
  end

  arpis_div #(.NW(NW), .TW(TW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .rem_o   (div_rem)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= '0;
      len_q    <= '0;
      ntot_q   <= '0;
      ctot_q   <= '0;
      npos_q   <= '0;
      cpos_q   <= '0;
      lwf_q    <= 1'b1;
      lfsr_q   <= arpis_pkg::LFSR_SEED;
      mode_q   <= arpis_pkg::MODE_UP;
      done_o   <= 1'b0;
      for (int k = 0; k < NUM_PADS; k++) begin
        ntab_q[k] <= '0;
        ctab_q[k] <= '0;
      end
    end else begin
      done_o <= cmd_i.fin;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (cmd_i.lfsr_adv) begin
        lfsr_q <= lfsr_nx;
      end
      if (cmd_i.apply) begin
        case (op_q)
          arpis_pkg::OP_ADD: begin
            if (add_ok) begin
              mask_q[pad_idx] <= 1'b1;
              len_q           <= len_q + LW'(1);
              ntab_q[pad_idx] <= nc_sat;
              ctab_q[pad_idx] <= cc_sat;
              ntot_q          <= ntot_q + TW'(nc_sat);
              ctot_q          <= ctot_q + TW'(cc_sat);
            end
          end
          arpis_pkg::OP_REMOVE: begin
            if (rem_ok) begin
              mask_q[pad_idx] <= 1'b0;
              len_q           <= len_q - LW'(1);
              ntab_q[pad_idx] <= '0;
              ctab_q[pad_idx] <= '0;
              ntot_q          <= ntot_q - TW'(ntab_q[pad_idx]);
              ctot_q          <= ctot_q - TW'(ctab_q[pad_idx]);
            end
          end
          arpis_pkg::OP_CLEAR: begin
            mask_q <= '0;
            len_q  <= '0;
            ntot_q <= '0;
            ctot_q <= '0;
            npos_q <= '0;
            cpos_q <= '0;
            lwf_q  <= 1'b1;
            for (int k = 0; k < NUM_PADS; k++) begin
              ntab_q[k] <= '0;
              ctab_q[k] <= '0;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.corr) begin
        if (ntot_q != '0) begin
          npos_q <= ncorr;
        end
        if (ctot_q != '0) begin
          cpos_q <= ccorr;
        end
      end
      if (cmd_i.arith) begin
        if (ntot_q != '0) begin
          npos_q <= nnext;
        end
        if (ctot_q != '0) begin
          cpos_q <= cnext;
        end
      end
      if (cmd_i.div_wr) begin
        case (div_sel_q)
          arpis_pkg::DIV_CC_POS: cpos_q <= (ctot_q == '0) ? '0 : div_rem;
          arpis_pkg::DIV_LFSR:   npos_q <= div_rem;
          default:               npos_q <= (ntot_q == '0) ? '0 : div_rem;
        endcase
      end
      if (cmd_i.fin && !cmd_i.fin_zero) begin
        lwf_q <= fwd_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q    <= arpis_pkg::op_e'(op_i);
      pad_q   <= pad_i;
      nc_q    <= pad_note_count_i;
      cc_q    <= pad_cc_count_i;
      fwd_q   <= forward_i;
      shift_q <= 2'sb00;
    end
    if (cmd_i.shift_set) begin
      shift_q <= lfsr_nx[0] ? 2'sb01 : 2'sb11;
    end
    if (cmd_i.apply && op_q == arpis_pkg::OP_ADD && add_ok) begin
      list_q[len_q[IW-1:0]] <= pad_q;
    end
    if (cmd_i.apply && op_q == arpis_pkg::OP_REMOVE && rem_ok) begin
      list_q <= list_d;
    end
    if (cmd_i.div_start) begin
      div_sel_q <= cmd_i.div_sel;
    end
    if (cmd_i.loc_clr) begin
      wi_q     <= '0;
      nrun_q   <= '0;
      crun_q   <= '0;
      nfound_q <= 1'b0;
      cfound_q <= 1'b0;
      npad_q   <= '0;
      cpad_q   <= '0;
      nloc_q   <= '0;
      cloc_q   <= '0;
    end else if (cmd_i.loc_step) begin
      wi_q   <= wi_q + LW'(1);
      nrun_q <= nsum;
      crun_q <= csum;
      if (!nfound_q && npos_q < nsum) begin
        nfound_q <= 1'b1;
        npad_q   <= p;
        nloc_q   <= 8'(npos_q - nrun_q);
      end
      if (!cfound_q && cpos_q < csum) begin
        cfound_q <= 1'b1;
        cpad_q   <= p;
        cloc_q   <= 8'(cpos_q - crun_q);
      end
    end
    if (cmd_i.fin) begin
      if (cmd_i.fin_zero) begin
        note_valid_o       <= 1'b0;
        note_pad_o         <= '0;
        note_local_index_o <= '0;
        octave_shift_o     <= 2'sb00;
        cc_valid_o         <= 1'b0;
        cc_pad_o           <= '0;
        cc_local_index_o   <= '0;
      end else begin
        note_valid_o       <= nfound_q;
        note_pad_o         <= npad_q;
        note_local_index_o <= nloc_q;
        octave_shift_o     <= shift_q;
        cc_valid_o         <= cfound_q;
        cc_pad_o           <= cpad_q;
        cc_local_index_o   <= cloc_q;
      end
    end
  end

  always_comb begin
    sts_o.op           = op_q;
    sts_o.fwd          = fwd_q;
    sts_o.mode         = mode_q;
    sts_o.rem_ok       = rem_ok;
    sts_o.totals_zero  = (ntot_q == '0) && (ctot_q == '0);
    sts_o.note_nonzero = (ntot_q != '0);
    sts_o.loc_done     = (wi_q == len_q);
    sts_o.div_done     = div_done;
    sts_o.lfsr_bit     = lfsr_nx[0];
    sts_o.note_found   = nfound_q;
    sts_o.next_zero    = (nnext == '0);
  end

endmodule

[rtl/arpis_ctrl.sv]
// ----------------------------------------------------------------------------
// arpis_ctrl
// controller state machine sequencing edits, walks and random draws
// ----------------------------------------------------------------------------
module arpis_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  arpis_pkg::sts_t sts_i,
  output arpis_pkg::cmd_t cmd_o
);

  arpis_pkg::state_e state_q, state_d;
  logic is_oct, is_rst;

  assign is_oct = (sts_i.mode == arpis_pkg::MODE_OCT_UP) ||
                  (sts_i.mode == arpis_pkg::MODE_OCT_DOWN);
  assign is_rst = (sts_i.mode == arpis_pkg::MODE_RST_UP) ||
                  (sts_i.mode == arpis_pkg::MODE_RST_DOWN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= arpis_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.div_sel = arpis_pkg::DIV_NOTE_POS;
    busy_o  = (state_q != arpis_pkg::ST_IDLE);
    case (state_q)
      arpis_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d = arpis_pkg::ST_APPLY;
        end
      end
      arpis_pkg::ST_APPLY: begin
        if (sts_i.op == arpis_pkg::OP_STEP) begin
          state_d = arpis_pkg::ST_STEP;
        end else begin
          cmd_o.apply = 1'b1;
          if (sts_i.op == arpis_pkg::OP_REMOVE && sts_i.rem_ok) begin
            state_d = arpis_pkg::ST_RDIV_N;
          end else begin
            state_d = arpis_pkg::ST_FIN;
          end
        end
      end
      arpis_pkg::ST_RDIV_N: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = arpis_pkg::DIV_NOTE_POS;
        state_d = arpis_pkg::ST_RWAIT_N;
      end
      arpis_pkg::ST_RWAIT_N: begin
        if (sts_i.div_done) begin
          cmd_o.div_wr = 1'b1;
          state_d = arpis_pkg::ST_RDIV_C;
        end
      end
      arpis_pkg::ST_RDIV_C: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = arpis_pkg::DIV_CC_POS;
        state_d = arpis_pkg::ST_RWAIT_C;
      end
      arpis_pkg::ST_RWAIT_C: begin
        if (sts_i.div_done) begin
          cmd_o.div_wr = 1'b1;
          state_d = arpis_pkg::ST_FIN;
        end
      end
      arpis_pkg::ST_STEP: begin
        if (sts_i.totals_zero) begin
          state_d = arpis_pkg::ST_FIN;
        end else begin
          cmd_o.corr    = 1'b1;
          cmd_o.loc_clr = 1'b1;
          state_d = arpis_pkg::ST_LOC;
        end
      end
      arpis_pkg::ST_LOC: begin
        if (sts_i.loc_done) begin
          state_d = sts_i.fwd ? arpis_pkg::ST_ARITH : arpis_pkg::ST_FIN;
        end else begin
          cmd_o.loc_step = 1'b1;
        end
      end
      arpis_pkg::ST_ARITH: begin
        cmd_o.arith = 1'b1;
        state_d = arpis_pkg::ST_FIN;
        if (sts_i.note_nonzero) begin
          if (sts_i.mode == arpis_pkg::MODE_RANDOM) begin
            state_d = arpis_pkg::ST_DRAW;
          end else if (is_oct) begin
            state_d = arpis_pkg::ST_OCT1;
          end else if (is_rst && sts_i.next_zero) begin
            state_d = arpis_pkg::ST_DRAW;
          end
        end
      end
      arpis_pkg::ST_OCT1: begin
        cmd_o.lfsr_adv = 1'b1;
        state_d = (sts_i.lfsr_bit && sts_i.note_found) ? arpis_pkg::ST_OCT2
                                                        : arpis_pkg::ST_FIN;
      end
      arpis_pkg::ST_OCT2: begin
        cmd_o.lfsr_adv  = 1'b1;
        cmd_o.shift_set = 1'b1;
        state_d = arpis_pkg::ST_FIN;
      end
      arpis_pkg::ST_DRAW: begin
        cmd_o.lfsr_adv  = 1'b1;
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = arpis_pkg::DIV_LFSR;
        state_d = arpis_pkg::ST_DWAIT;
      end
      arpis_pkg::ST_DWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.div_wr = 1'b1;
          state_d = arpis_pkg::ST_FIN;
        end
      end
      arpis_pkg::ST_FIN: begin
        cmd_o.fin      = 1'b1;
        cmd_o.fin_zero = (sts_i.op != arpis_pkg::OP_STEP) || sts_i.totals_zero;
        state_d = arpis_pkg::ST_IDLE;
      end
      default: begin
        state_d = arpis_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && state_q == arpis_pkg::ST_IDLE) |=> state_q == arpis_pkg::ST_APPLY)
    else $error("accepted beat did not start work");
  a_fin_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == arpis_pkg::ST_FIN |=> state_q == arpis_pkg::ST_IDLE)
    else $error("result beat not followed by idle");
  a_draw_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == arpis_pkg::ST_DWAIT && sts_i.div_done) |=> state_q == arpis_pkg::ST_FIN)
    else $error("draw completion lost");
  a_div_wr_only_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_wr |-> sts_i.div_done)
    else $error("remainder written before divider finished");
`endif

endmodule

[rtl/arpeggiator_index_sequencer_core.sv]
// ----------------------------------------------------------------------------
// arpeggiator_index_sequencer_core
// held-pad list and note/cc index walker for an arpeggiator
// ----------------------------------------------------------------------------
// One item is taken when start is high and busy is low; exactly one result
// beat follows, shown for one cycle with done_o high, and the receiver cannot
// stall it. Add, clear and an ignored remove go from the apply state straight
// to the result beat. A remove that hits then reduces both positions modulo
// the new totals, one after the other, in the shared remainder unit, whose
// numerator is NW = max(16, total width) bits wide. A step corrects the
// positions and walks the held list; when forward it then advances the
// positions, and may add one or two lfsr draws for an octave shift or a random
// draw through the bit-serial remainder unit. With 16 pads the totals are 12
// bits wide. arp_mode may be written only while busy is low.
// ----------------------------------------------------------------------------
module arpeggiator_index_sequencer_core #(
  parameter int NUM_PADS    = 16,
  parameter int MAX_PER_PAD = 255
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command side
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        op_i,
  input  logic [3:0]        pad_i,
  input  logic [7:0]        pad_note_count_i,
  input  logic [7:0]        pad_cc_count_i,
  input  logic              forward_i,
  // arp_mode register
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_wdata_i,
  // result beat
  output logic              done_o,
  output logic              note_valid_o,
  output logic [3:0]        note_pad_o,
  output logic [7:0]        note_local_index_o,
  output logic signed [1:0] octave_shift_o,
  output logic              cc_valid_o,
  output logic [3:0]        cc_pad_o,
  output logic [7:0]        cc_local_index_o
);

  arpis_pkg::cmd_t cmd;
  arpis_pkg::sts_t sts;

  // sequencing of edits, list walk and draws
  arpis_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  // state, arithmetic and result registers
  arpis_dp #(
    .NUM_PADS    (NUM_PADS),
    .MAX_PER_PAD (MAX_PER_PAD)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .op_i               (op_i),
    .pad_i              (pad_i),
    .pad_note_count_i   (pad_note_count_i),
    .pad_cc_count_i     (pad_cc_count_i),
    .forward_i          (forward_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .done_o             (done_o),
    .note_valid_o       (note_valid_o),
    .note_pad_o         (note_pad_o),
    .note_local_index_o (note_local_index_o),
    .octave_shift_o     (octave_shift_o),
    .cc_valid_o         (cc_valid_o),
    .cc_pad_o           (cc_pad_o),
    .cc_local_index_o   (cc_local_index_o)
  );

endmodule

[verif/arpeggiator_index_sequencer_core_tb.sv]
// ----------------------------------------------------------------------------
// arpeggiator_index_sequencer_core_tb
// self-checking bench for the held-pad list and index walker
// ----------------------------------------------------------------------------
// Commands go in over start/busy and each command yields one result beat on
// done_o. A behavioral copy of the sequencer, with its own list, tables,
// positions and lfsr, predicts every beat at the moment the command is taken.
// A directed pass covers the corner cases. Random traffic then runs under
// every arp_mode setting, the unused code 7 included. Send gaps vary
// throughout the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arpeggiator_index_sequencer_core_tb;

  localparam int          NPADS       = 16;
  localparam int          PAD_MAX     = 255;
  localparam logic [2:0]  MODE_UNUSED = 3'd7;
  localparam int          SETTLE      = 64;   // covers the slowest command
  localparam int          RAND_PER_MODE = 135;

  typedef struct packed {
    logic              note_valid;
    logic [3:0]        note_pad;
    logic [7:0]        note_local;
    logic signed [1:0] oct;
    logic              cc_valid;
    logic [3:0]        cc_pad;
    logic [7:0]        cc_local;
  } beat_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        op_i = '0;
  logic [3:0]        pad_i = '0;
  logic [7:0]        pad_note_count_i = '0;
  logic [7:0]        pad_cc_count_i = '0;
  logic              forward_i = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [2:0]        cfg_wdata_i = '0;
  logic              done_o;
  logic              note_valid_o;
  logic [3:0]        note_pad_o;
  logic [7:0]        note_local_index_o;
  logic signed [1:0] octave_shift_o;
  logic              cc_valid_o;
  logic [3:0]        cc_pad_o;
  logic [7:0]        cc_local_index_o;

  arpeggiator_index_sequencer_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .op_i               (op_i),
    .pad_i              (pad_i),
    .pad_note_count_i   (pad_note_count_i),
    .pad_cc_count_i     (pad_cc_count_i),
    .forward_i          (forward_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .done_o             (done_o),
    .note_valid_o       (note_valid_o),
    .note_pad_o         (note_pad_o),
    .note_local_index_o (note_local_index_o),
    .octave_shift_o     (octave_shift_o),
    .cc_valid_o         (cc_valid_o),
    .cc_pad_o           (cc_pad_o),
    .cc_local_index_o   (cc_local_index_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // sequencer state mirror
  // ---------------------------------------------------------------------------
  int          held_order [NPADS];
  int          held_len;
  int          note_cnt [NPADS];
  int          cc_cnt [NPADS];
  int          note_sum, cc_sum;
  int          note_pos, cc_pos;
  bit          prev_fwd;
  logic [15:0] rng;
  logic [2:0]  cur_mode;

  beat_t       pending_beats [$];
  int          mismatches;

  function automatic void mirror_reset();
    for (int i = 0; i < NPADS; i++) begin
      held_order[i] = 0;
      note_cnt[i]   = 0;
      cc_cnt[i]     = 0;
    end
    held_len = 0;
    note_sum = 0;
    cc_sum   = 0;
    note_pos = 0;
    cc_pos   = 0;
    prev_fwd = 1'b1;
    rng      = arpis_pkg::LFSR_SEED;
    cur_mode = arpis_pkg::MODE_UP;
  endfunction

  // galois lfsr advances once per draw, then the new value mod n
  function automatic int rng_draw(int n);
    logic lsb;
    lsb = rng[0];
    rng = rng >> 1;
    if (lsb) rng = rng ^ arpis_pkg::LFSR_TAPS;
    return (n == 0) ? 0 : int'(rng) % n;
  endfunction

  // flat index over the held list to pad and local index
  function automatic bit find_slot(bit use_cc, int flat, output int pad, output int idx);
    int run, c;
    run = 0;
    pad = 0;
    idx = 0;
    for (int i = 0; i < held_len; i++) begin
      c = use_cc ? cc_cnt[held_order[i]] : note_cnt[held_order[i]];
      if (flat < run + c) begin
        pad = held_order[i];
        idx = flat - run;
        return 1'b1;
      end
      run += c;
    end
    return 1'b0;
  endfunction

  // direction change correction
  function automatic int turn_fix(int pos, int total, bit fwd);
    pos = pos % total;
    if (!fwd) return (pos + 2 * total - (prev_fwd ? 2 : 1)) % total;
    if (!prev_fwd) return (pos + 1) % total;
    return pos;
  endfunction

  function automatic beat_t predict_beat(arpis_pkg::op_e op, int pad, int nc, int cc,
                                         bit fwd);
    beat_t r;
    int    hit, p, l, cur, nxt, shift;
    bit    has;
    r = '0;
    case (op)
      arpis_pkg::OP_ADD: begin
        hit = 0;
        for (int i = 0; i < held_len; i++) if (held_order[i] == pad) hit = 1;
        if (!hit && held_len < NPADS) begin
          if (nc > PAD_MAX) nc = PAD_MAX;
          if (cc > PAD_MAX) cc = PAD_MAX;
          held_order[held_len] = pad;
          held_len++;
          note_cnt[pad] = nc;
          cc_cnt[pad]   = cc;
          note_sum += nc;
          cc_sum   += cc;
        end
      end
      arpis_pkg::OP_REMOVE: begin
        hit = -1;
        for (int i = held_len - 1; i >= 0; i--) if (held_order[i] == pad) hit = i;
        if (hit >= 0) begin
          for (int j = hit; j + 1 < held_len; j++) held_order[j] = held_order[j + 1];
          held_len--;
          note_sum -= note_cnt[pad];
          cc_sum   -= cc_cnt[pad];
          note_cnt[pad] = 0;
          cc_cnt[pad]   = 0;
          note_pos = note_sum ? note_pos % note_sum : 0;
          cc_pos   = cc_sum ? cc_pos % cc_sum : 0;
        end
      end
      arpis_pkg::OP_CLEAR: begin
        for (int i = 0; i < NPADS; i++) begin
          note_cnt[i] = 0;
          cc_cnt[i]   = 0;
        end
        held_len = 0;
        note_sum = 0;
        cc_sum   = 0;
        note_pos = 0;
        cc_pos   = 0;
        prev_fwd = 1'b1;
      end
      default: begin
        if (note_sum != 0 || cc_sum != 0) begin
          if (note_sum > 0) begin
            shift = 0;
            note_pos = turn_fix(note_pos, note_sum, fwd);
            cur = note_pos;
            has = find_slot(1'b0, cur, p, l);
            if (has) begin
              r.note_valid = 1'b1;
              r.note_pad   = p[3:0];
              r.note_local = l[7:0];
            end
            if (fwd) begin
              case (cur_mode)
                arpis_pkg::MODE_DOWN:   nxt = (cur + note_sum - 1) % note_sum;
                arpis_pkg::MODE_RANDOM: nxt = rng_draw(note_sum);
                arpis_pkg::MODE_OCT_UP, arpis_pkg::MODE_OCT_DOWN: begin
                  nxt = (cur_mode == arpis_pkg::MODE_OCT_UP)
                        ? (cur + 1) % note_sum
                        : (cur + note_sum - 1) % note_sum;
                  // second draw only when the first one asks for a shift
                  if (rng_draw(2) == 1 && has) shift = (rng_draw(2) == 1) ? 1 : -1;
                end
                arpis_pkg::MODE_RST_UP, arpis_pkg::MODE_RST_DOWN: begin
                  nxt = (cur_mode == arpis_pkg::MODE_RST_UP)
                        ? (cur + 1) % note_sum
                        : (cur + note_sum - 1) % note_sum;
                  if (nxt == 0) nxt = rng_draw(note_sum);
                end
                default:     nxt = (cur + 1) % note_sum;
              endcase
              note_pos = nxt;
            end
            r.oct = shift[1:0];
          end
          if (cc_sum > 0) begin
            cc_pos = turn_fix(cc_pos, cc_sum, fwd);
            if (find_slot(1'b1, cc_pos, p, l)) begin
              r.cc_valid = 1'b1;
              r.cc_pad   = p[3:0];
              r.cc_local = l[7:0];
            end
            if (fwd) cc_pos = (cc_pos + 1) % cc_sum;
          end
          prev_fwd = fwd;
        end
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: values sampled at the edge that ends the beat
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    beat_t got, want;
    if (rst_ni && done_o) begin
      got = {note_valid_o, note_pad_o, note_local_index_o, octave_shift_o,
             cc_valid_o, cc_pad_o, cc_local_index_o};
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = pending_beats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp nv=%0d np=%0d ni=%0d oct=%0d cv=%0d cp=%0d ci=%0d",
                      " / act nv=%0d np=%0d ni=%0d oct=%0d cv=%0d cp=%0d ci=%0d"},
                     want.note_valid, want.note_pad, want.note_local, want.oct,
                     want.cc_valid, want.cc_pad, want.cc_local,
                     got.note_valid, got.note_pad, got.note_local, got.oct,
                     got.cc_valid, got.cc_pad, got.cc_local);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers, called right after a rising edge
  // ---------------------------------------------------------------------------
  task automatic send_cmd(arpis_pkg::op_e op, int pad, int nc, int cc, bit fwd);
    int    gap;
    beat_t nxt_beat;
    op_i             <= op;
    pad_i            <= pad[3:0];
    pad_note_count_i <= nc[7:0];
    pad_cc_count_i   <= cc[7:0];
    forward_i        <= fwd;
    start            <= 1'b1;
    // busy read here is the value before the edge
    do @(posedge clk_i); while (busy);
    nxt_beat = predict_beat(op, pad & 15, nc & 255, cc & 255, fwd);
    pending_beats = {pending_beats, nxt_beat};
    // mostly back to back or short, now and then a long pause
    case ($urandom_range(0, 9))
      0, 1, 2, 3: gap = 0;
      9:          gap = $urandom_range(15, 70);
      default:    gap = $urandom_range(1, 4);
    endcase
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // let everything drain so the block is idle
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_mode(logic [2:0] m);
    cfg_wdata_i <= m;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_mode = m;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    send_cmd(arpis_pkg::OP_STEP, 0, 0, 0, 1'b1);          // nothing held
    send_cmd(arpis_pkg::OP_REMOVE, 5, 0, 0, 1'b0);        // unheld pad
    send_cmd(arpis_pkg::OP_ADD, 15, 255, 0, 1'b0);        // widest note count, no cc
    send_cmd(arpis_pkg::OP_ADD, 0, 0, 255, 1'b1);         // no notes, widest cc count
    send_cmd(arpis_pkg::OP_ADD, 15, 3, 3, 1'b0);          // duplicate is ignored
    send_cmd(arpis_pkg::OP_ADD, 10, 1, 1, 1'b0);
    send_cmd(arpis_pkg::OP_STEP, 0, 0, 0, 1'b1);
    send_cmd(arpis_pkg::OP_STEP, 0, 0, 0, 1'b0);          // direction change
    send_cmd(arpis_pkg::OP_STEP, 0, 0, 0, 1'b0);
    send_cmd(arpis_pkg::OP_STEP, 0, 0, 0, 1'b1);
    send_cmd(arpis_pkg::OP_REMOVE, 15, 0, 0, 1'b0);
    send_cmd(arpis_pkg::OP_STEP, 0, 0, 0, 1'b1);
    send_cmd(arpis_pkg::OP_CLEAR, 0, 0, 0, 1'b0);
    send_cmd(arpis_pkg::OP_STEP, 0, 0, 0, 1'b0);
    // fill the whole list, then one more add on a full list
    for (int p = 0; p < NPADS; p++)
      send_cmd(arpis_pkg::OP_ADD, p, p == 3 ? 0 : 2, p % 3, 1'b1);
    send_cmd(arpis_pkg::OP_ADD, 7, 9, 9, 1'b1);
    send_cmd(arpis_pkg::OP_STEP, 0, 0, 0, 1'b0);
    send_cmd(arpis_pkg::OP_CLEAR, 0, 0, 0, 1'b1);
    wait_idle();
  endtask

  function automatic int pick_count();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 255;
      2:       return $urandom_range(0, 255);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  // mostly steps over a populated list, with adds, removes and the odd clear mixed in
  task automatic test_random_mode(logic [2:0] m);
    int sel;
    write_mode(m);
    for (int n = 0; n < RAND_PER_MODE; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 55 && held_len > 0)
        send_cmd(arpis_pkg::OP_STEP, $urandom_range(0, 15), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 3) != 0);
      else if (sel < 80 || held_len == 0)
        send_cmd(arpis_pkg::OP_ADD, $urandom_range(0, 15), pick_count(), pick_count(),
                 $urandom_range(0, 1));
      else if (sel < 97)
        send_cmd(arpis_pkg::OP_REMOVE, $urandom_range(0, 15), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 1));
      else
        send_cmd(arpis_pkg::OP_CLEAR, $urandom_range(0, 15), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 1));
    end
    wait_idle();
  endtask

  initial begin
    mismatches = 0;
    mirror_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    // extremes first, then the rest, the unused code included
    test_random_mode(arpis_pkg::MODE_RST_DOWN);
    test_random_mode(arpis_pkg::MODE_UP);
    test_random_mode(arpis_pkg::MODE_DOWN);
    test_random_mode(arpis_pkg::MODE_RANDOM);
    test_random_mode(arpis_pkg::MODE_OCT_UP);
    test_random_mode(arpis_pkg::MODE_OCT_DOWN);
    test_random_mode(arpis_pkg::MODE_RST_UP);
    test_random_mode(MODE_UNUSED);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("[arpeggiator_index_sequencer_core] OK");
    end else begin
      $display("[arpeggiator_index_sequencer_core] ERROR");
    end
    $finish;
  end

  // run limit, well past the slowest legal run
  initial begin
    #20ms;
    $display("[arpeggiator_index_sequencer_core] ERROR");
    $finish;
  end

endmodule
